FILE: rtl/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int TIME_BITS_DEF = 16;
   localparam int PRIO_BITS_DEF = 8;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic load_end;
      logic tick_end;
   } cmd_type;

   typedef struct packed {
      logic table_empty;
      logic scan_last;
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/preemptive_priority_scheduler.sv
// load item: accept -> load state (entry written) -> result strobe registered from it; busy until idle
// tick item: accept -> scan state, reading one entry per cycle from the task ram for each task
//   loaded, then the drain and update states, with the result strobe registered from update;
//   an empty table skips the scan and drain and goes straight to update
// the result is strobed for one cycle and cannot be stalled; a new item may start that cycle
// reset (synchronous): task count, done count and time go to zero; table contents stay
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler #(
   parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
   parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF,
   localparam int CNT_W = $clog2(MAX_TASKS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_opcode,
   input  wire logic [TIME_BITS-1:0] req_arrival_time,
   input  wire logic [TIME_BITS-1:0] req_burst_length,
   input  wire logic [PRIO_BITS-1:0] req_task_priority,
   output logic                      rsp_strobe,
   output logic                      rsp_status,
   output logic [CNT_W-1:0]          rsp_running_id,
   output logic                      rsp_finished,
   output logic [TIME_BITS-1:0]      rsp_completion_time,
   output logic [TIME_BITS-1:0]      rsp_turnaround_time,
   output logic [TIME_BITS-1:0]      rsp_waiting_time,
   output logic                      rsp_all_done,
   output logic [TIME_BITS-1:0]      rsp_current_time
);

   pps_pkg::cmd_type  cmd;
   pps_pkg::stat_type stat;

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   pps_dp #(
      .MAX_TASKS (MAX_TASKS),
      .TIME_BITS (TIME_BITS),
      .PRIO_BITS (PRIO_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_arrival_time    (req_arrival_time),
      .req_burst_length    (req_burst_length),
      .req_task_priority   (req_task_priority),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_running_id      (rsp_running_id),
      .rsp_finished        (rsp_finished),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_all_done        (rsp_all_done),
      .rsp_current_time    (rsp_current_time)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make the block busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while still busy");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status |-> (rsp_running_id == '0) && !rsp_finished)
      else $error("rejected load reports a running task");

   a_finish_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_finished |->
         (rsp_running_id != '0) && (rsp_waiting_time <= rsp_turnaround_time))
      else $error("completion without a task or waiting above turnaround");

endmodule

`default_nettype wire

FILE: rtl/pps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_ram #(
   parameter int WIDTH = pps_pkg::TIME_BITS_DEF,
   parameter int DEPTH = pps_pkg::MAX_TASKS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/pps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              req_opcode,
   input  wire pps_pkg::stat_type stat,
   output pps_pkg::cmd_type       cmd,
   output logic                   busy
);

   pps_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (start) begin
               if (req_opcode == pps_pkg::OP_LOAD) begin
                  state_in = pps_pkg::ST_LOAD;
               end else if (stat.table_empty) begin
                  state_in = pps_pkg::ST_UPDATE;
               end else begin
                  state_in = pps_pkg::ST_SCAN;
               end
            end
         end
         pps_pkg::ST_LOAD:   state_in = pps_pkg::ST_IDLE;
         pps_pkg::ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = pps_pkg::ST_DRAIN;
            end
         end
         pps_pkg::ST_DRAIN:  state_in = pps_pkg::ST_UPDATE;
         pps_pkg::ST_UPDATE: state_in = pps_pkg::ST_IDLE;
         default:            state_in = pps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         pps_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         pps_pkg::ST_LOAD:   cmd.load_end  = 1'b1;
         pps_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
         pps_pkg::ST_DRAIN:  cmd           = '0;
         pps_pkg::ST_UPDATE: cmd.tick_end  = 1'b1;
         default:            busy          = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pps_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_dp #(
   parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
   parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF,
   localparam int CNT_W = $clog2(MAX_TASKS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pps_pkg::cmd_type     cmd,
   output pps_pkg::stat_type         stat,
   input  wire logic [TIME_BITS-1:0] req_arrival_time,
   input  wire logic [TIME_BITS-1:0] req_burst_length,
   input  wire logic [PRIO_BITS-1:0] req_task_priority,
   output logic                      rsp_strobe,
   output logic                      rsp_status,
   output logic [CNT_W-1:0]          rsp_running_id,
   output logic                      rsp_finished,
   output logic [TIME_BITS-1:0]      rsp_completion_time,
   output logic [TIME_BITS-1:0]      rsp_turnaround_time,
   output logic [TIME_BITS-1:0]      rsp_waiting_time,
   output logic                      rsp_all_done,
   output logic [TIME_BITS-1:0]      rsp_current_time
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int ENT_W = 2 * TIME_BITS + PRIO_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_TASKS);

   // captured request
   logic [TIME_BITS-1:0] arr_ff, arr_in;
   logic [TIME_BITS-1:0] bur_ff, bur_in;
   logic [PRIO_BITS-1:0] pri_ff, pri_in;

   // scheduler state
   logic [CNT_W-1:0]     task_count_ff, task_count_in;
   logic [CNT_W-1:0]     done_count_ff, done_count_in;
   logic [TIME_BITS-1:0] time_ff, time_in;

   // scan and running best
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [PRIO_BITS-1:0] best_pri_ff, best_pri_in;
   logic [TIME_BITS-1:0] best_arr_ff, best_arr_in;
   logic [TIME_BITS-1:0] best_bur_ff, best_bur_in;
   logic [TIME_BITS-1:0] best_rem_ff, best_rem_in;

   // result register
   logic                 strobe_ff, strobe_in;
   logic                 status_ff, status_in;
   logic [CNT_W-1:0]     run_id_ff, run_id_in;
   logic                 fin_ff, fin_in;
   logic [TIME_BITS-1:0] comp_ff, comp_in;
   logic [TIME_BITS-1:0] tat_ff, tat_in;
   logic [TIME_BITS-1:0] wt_ff, wt_in;
   logic                 all_done_ff, all_done_in;
   logic [TIME_BITS-1:0] cur_time_ff, cur_time_in;

   // memory ports
   logic                 a_we, b_we;
   logic [IDX_W-1:0]     a_waddr, b_waddr;
   logic [ENT_W-1:0]     a_wdata, a_rdata;
   logic [TIME_BITS-1:0] b_wdata, b_rdata;

   logic [TIME_BITS-1:0] ent_arr, ent_bur, ent_rem;
   logic [PRIO_BITS-1:0] ent_pri;
   logic                 ent_ready, ent_better, take;
   logic                 load_ok, fin;
   logic [TIME_BITS-1:0] rem_dec, comp, tat, wt;

   assign ent_arr = a_rdata[ENT_W-1 -: TIME_BITS];
   assign ent_bur = a_rdata[PRIO_BITS +: TIME_BITS];
   assign ent_pri = a_rdata[PRIO_BITS-1:0];
   assign ent_rem = b_rdata;

   // lower index wins ties by scan order
   assign ent_ready  = (ent_arr <= time_ff) && (ent_rem != '0);
   assign ent_better = !found_ff || (ent_pri < best_pri_ff)
                       || ((ent_pri == best_pri_ff) && (ent_arr < best_arr_ff));
   assign take       = cmp_valid_ff && ent_ready && ent_better;

   assign load_ok = (task_count_ff != FULL_COUNT) && (bur_ff != '0);
   assign rem_dec = best_rem_ff - TIME_BITS'(1);
   assign fin     = found_ff && (rem_dec == '0);
   assign comp    = (time_ff == TIME_MAX) ? TIME_MAX : time_ff + TIME_BITS'(1);
   assign tat     = comp - best_arr_ff;
   assign wt      = (tat >= best_bur_ff) ? tat - best_bur_ff : '0;

   assign stat.table_empty = (task_count_ff == '0);
   assign stat.scan_last   = (scan_idx_ff == IDX_W'(task_count_ff - CNT_W'(1)));

   assign a_we    = cmd.load_end && load_ok;
   assign a_waddr = task_count_ff[IDX_W-1:0];
   assign a_wdata = {arr_ff, bur_ff, pri_ff};
   assign b_we    = a_we || (cmd.tick_end && found_ff);
   assign b_waddr = cmd.tick_end ? best_idx_ff : a_waddr;
   assign b_wdata = cmd.tick_end ? rem_dec : bur_ff;

   pps_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_TASKS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_en   (cmd.scan_step),
      .rd_addr (scan_idx_ff),
      .rd_data (a_rdata)
   );

   pps_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_TASKS)
   ) u_remain_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_en   (cmd.scan_step),
      .rd_addr (scan_idx_ff),
      .rd_data (b_rdata)
   );

   always_comb begin
      arr_in = cmd.capture ? req_arrival_time  : arr_ff;
      bur_in = cmd.capture ? req_burst_length  : bur_ff;
      pri_in = cmd.capture ? req_task_priority : pri_ff;

      task_count_in = a_we ? task_count_ff + CNT_W'(1) : task_count_ff;
      done_count_in = (cmd.tick_end && fin) ? done_count_ff + CNT_W'(1) : done_count_ff;
      time_in       = cmd.tick_end ? comp : time_ff;

      priority if (cmd.capture) begin
         scan_idx_in = '0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end else begin
         scan_idx_in = scan_idx_ff;
      end
      cmp_valid_in = cmd.scan_step;
      cmp_idx_in   = scan_idx_ff;

      found_in    = cmd.capture ? 1'b0 : (found_ff || take);
      best_idx_in = take ? cmp_idx_ff : best_idx_ff;
      best_pri_in = take ? ent_pri    : best_pri_ff;
      best_arr_in = take ? ent_arr    : best_arr_ff;
      best_bur_in = take ? ent_bur    : best_bur_ff;
      best_rem_in = take ? ent_rem    : best_rem_ff;

      strobe_in   = cmd.load_end || cmd.tick_end;
      status_in   = cmd.load_end && !load_ok;
      run_id_in   = (cmd.tick_end && found_ff) ? CNT_W'(best_idx_ff) + CNT_W'(1) : '0;
      fin_in      = cmd.tick_end && fin;
      comp_in     = fin_in ? comp : '0;
      tat_in      = fin_in ? tat  : '0;
      wt_in       = fin_in ? wt   : '0;
      all_done_in = (done_count_in == task_count_in);
      cur_time_in = time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         done_count_ff <= '0;
         time_ff       <= '0;
         scan_idx_ff   <= '0;
         cmp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         task_count_ff <= task_count_in;
         done_count_ff <= done_count_in;
         time_ff       <= time_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_valid_ff  <= cmp_valid_in;
         found_ff      <= found_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      arr_ff      <= arr_in;
      bur_ff      <= bur_in;
      pri_ff      <= pri_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_pri_ff <= best_pri_in;
      best_arr_ff <= best_arr_in;
      best_bur_ff <= best_bur_in;
      best_rem_ff <= best_rem_in;
      if (strobe_in) begin
         status_ff   <= status_in;
         run_id_ff   <= run_id_in;
         fin_ff      <= fin_in;
         comp_ff     <= comp_in;
         tat_ff      <= tat_in;
         wt_ff       <= wt_in;
         all_done_ff <= all_done_in;
         cur_time_ff <= cur_time_in;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_running_id      = run_id_ff;
   assign rsp_finished        = fin_ff;
   assign rsp_completion_time = comp_ff;
   assign rsp_turnaround_time = tat_ff;
   assign rsp_waiting_time    = wt_ff;
   assign rsp_all_done        = all_done_ff;
   assign rsp_current_time    = cur_time_ff;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int TW = pps_pkg::TIME_BITS_DEF;
   localparam int PW = pps_pkg::PRIO_BITS_DEF;
   localparam int NT = pps_pkg::MAX_TASKS_DEF;
   localparam int CW = $clog2(NT + 1);
   localparam logic [TW-1:0] TIME_MAX = '1;
   // random phase loads only a few tasks, the full-table phase fills the rest
   localparam int SPARSE_TASKS = 9;
   localparam int unsigned CYCLE_LIMIT = 200_000;

   typedef struct packed {
      logic          status;
      logic [CW-1:0] running_id;
      logic          finished;
      logic [TW-1:0] completion_time;
      logic [TW-1:0] turnaround_time;
      logic [TW-1:0] waiting_time;
      logic          all_done;
      logic [TW-1:0] current_time;
   } sched_result_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          start;
   logic          busy;
   logic          req_opcode;
   logic [TW-1:0] req_arrival_time;
   logic [TW-1:0] req_burst_length;
   logic [PW-1:0] req_task_priority;
   logic          rsp_strobe;
   logic          rsp_status;
   logic [CW-1:0] rsp_running_id;
   logic          rsp_finished;
   logic [TW-1:0] rsp_completion_time;
   logic [TW-1:0] rsp_turnaround_time;
   logic [TW-1:0] rsp_waiting_time;
   logic          rsp_all_done;
   logic [TW-1:0] rsp_current_time;

   // scheduler state as predicted
   logic [TW-1:0] arrival_tbl[NT];
   logic [TW-1:0] burst_tbl[NT];
   logic [TW-1:0] left_tbl[NT];
   logic [PW-1:0] prio_tbl[NT];
   int            tasks_loaded = 0;
   int            tasks_done = 0;
   logic [TW-1:0] sched_time = '0;

   sched_result_type pending_results[$];
   int unsigned   mismatches = 0;
   int unsigned   cycle_count = 0;
   bit            gaps_on = 1'b1;

   preemptive_priority_scheduler uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_arrival_time    (req_arrival_time),
      .req_burst_length    (req_burst_length),
      .req_task_priority   (req_task_priority),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_running_id      (rsp_running_id),
      .rsp_finished        (rsp_finished),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_all_done        (rsp_all_done),
      .rsp_current_time    (rsp_current_time)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still pending", cycle_count,
                  pending_results.size());
         $display("** preemptive_priority_scheduler: FAILED **");
         $finish;
      end
   end

   // one item through the predicted scheduler
   function automatic sched_result_type schedule_step(input logic op,
                                                      input logic [TW-1:0] arr,
                                                      input logic [TW-1:0] bur,
                                                      input logic [PW-1:0] pri);
      sched_result_type r;
      int            pick;
      bit            found;
      r = '0;
      pick = 0;
      found = 1'b0;
      if (op == pps_pkg::OP_LOAD) begin
         if (tasks_loaded >= NT || bur == '0) begin
            r.status = 1'b1;
         end else begin
            arrival_tbl[tasks_loaded] = arr;
            burst_tbl[tasks_loaded] = bur;
            left_tbl[tasks_loaded] = bur;
            prio_tbl[tasks_loaded] = pri;
            tasks_loaded++;
         end
      end else begin
         for (int i = 0; i < tasks_loaded; i++) begin
            if (arrival_tbl[i] <= sched_time && left_tbl[i] != '0) begin
               if (!found || prio_tbl[i] < prio_tbl[pick] ||
                   (prio_tbl[i] == prio_tbl[pick] && arrival_tbl[i] < arrival_tbl[pick])) begin
                  pick = i;
                  found = 1'b1;
               end
            end
         end
         if (found) begin
            r.running_id = CW'(pick + 1);
            left_tbl[pick] = left_tbl[pick] - 1'b1;
            if (left_tbl[pick] == '0) begin
               r.finished = 1'b1;
               r.completion_time = (sched_time == TIME_MAX) ? sched_time : sched_time + 1'b1;
               r.turnaround_time = r.completion_time - arrival_tbl[pick];
               // saturated time can leave turnaround below burst
               r.waiting_time = (r.turnaround_time >= burst_tbl[pick]) ?
                                r.turnaround_time - burst_tbl[pick] : '0;
               tasks_done++;
            end
         end
         if (sched_time != TIME_MAX) begin
            sched_time = sched_time + 1'b1;
         end
      end
      r.all_done = (tasks_done == tasks_loaded);
      r.current_time = sched_time;
      return r;
   endfunction

   task automatic send_item(input logic op, input logic [TW-1:0] arr, input logic [TW-1:0] bur,
                            input logic [PW-1:0] pri);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_arrival_time <= arr;
      req_burst_length <= bur;
      req_task_priority <= pri;
      do @(posedge clock); while (busy);
      pending_results.insert(pending_results.size(), schedule_step(op, arr, bur, pri));
   endtask

   task automatic check_field(input string name, input logic [TW-1:0] want,
                              input logic [TW-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch in %s at cycle %0d: expected %0d, got %0d", name, cycle_count,
                     want, got);
         end
      end
   endtask

   always @(posedge clock) begin : result_check
      sched_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result with no item pending at cycle %0d", cycle_count);
            end
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("running_id", want.running_id, rsp_running_id);
            check_field("finished", want.finished, rsp_finished);
            check_field("completion_time", want.completion_time, rsp_completion_time);
            check_field("turnaround_time", want.turnaround_time, rsp_turnaround_time);
            check_field("waiting_time", want.waiting_time, rsp_waiting_time);
            check_field("all_done", want.all_done, rsp_all_done);
            check_field("current_time", want.current_time, rsp_current_time);
         end
      end
   end

   task automatic test_directed();
      send_item(pps_pkg::OP_TICK, '0, '0, '0);    // empty table: idle, all done
      send_item(pps_pkg::OP_LOAD, '1, '0, '1);    // zero burst
      send_item(pps_pkg::OP_LOAD, 1, 2, 7);
      send_item(pps_pkg::OP_LOAD, 0, 1, 7);       // same priority, earlier arrival goes first
      send_item(pps_pkg::OP_LOAD, 1, 1, 7);       // full tie with the first task, lower index
      send_item(pps_pkg::OP_LOAD, 3, 2, 0);       // preempts when it arrives
      repeat (7) send_item(pps_pkg::OP_TICK, '1, '1, '1);
      send_item(pps_pkg::OP_LOAD, '1, '1, '1);    // ready only once time saturates
      send_item(pps_pkg::OP_LOAD, 0, 3, 1);       // loaded late, arrival already past
      repeat (4) send_item(pps_pkg::OP_TICK, '0, '0, '0);
   endtask

   task automatic test_random_arrivals(input int count);
      logic [TW-1:0] a;
      logic [TW-1:0] b;
      logic [PW-1:0] p;
      for (int k = 0; k < count; k++) begin
         a = TW'($urandom);
         b = TW'($urandom);
         p = PW'($urandom);
         if ($urandom_range(0, 9) != 0) begin
            send_item(pps_pkg::OP_TICK, a, b, p);
         end else if (tasks_loaded < SPARSE_TASKS && $urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 3) != 0) begin
               a = sched_time + TW'($urandom_range(0, 40));
            end else begin
               a = TW'($urandom_range(0, sched_time));
            end
            b = ($urandom_range(0, 3) != 0) ? TW'($urandom_range(1, 60)) :
                                              TW'($urandom_range(61, 2000));
            send_item(pps_pkg::OP_LOAD, a, b, PW'($urandom_range(0, 255)));
         end else begin
            send_item(pps_pkg::OP_LOAD, a, '0, p);
         end
      end
   endtask

   task automatic test_full_table(input int count, input int quiet_tail);
      logic [TW-1:0] a;
      logic [TW-1:0] b;
      logic [PW-1:0] p;
      for (int k = 0; k < count; k++) begin
         gaps_on = (k < count - quiet_tail);
         a = TW'($urandom);
         b = TW'($urandom);
         p = PW'($urandom);
         if ($urandom_range(0, 3) != 0) begin
            send_item(pps_pkg::OP_TICK, a, b, p);
         end else begin
            case ($urandom_range(0, 7))
               0: b = '0;
               1: p = '1;    // long burst at the lowest priority, runs only when nothing else does
               default: b = TW'($urandom_range(1, 30));
            endcase
            send_item(pps_pkg::OP_LOAD, a, b, p);
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_opcode <= pps_pkg::OP_LOAD;
      req_arrival_time <= '0;
      req_burst_length <= '0;
      req_task_priority <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_arrivals(500);
      test_full_table(650, 150);

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      if (mismatches == 0) begin
         $display("** preemptive_priority_scheduler: PASSED **");
      end else begin
         $display("** preemptive_priority_scheduler: FAILED **");
      end
      $finish;
   end

endmodule
